[design/ppid_pkg.sv]
// ----------------------------------------------------------------------------
// ppid_pkg : shared types and constants of the polar PID drive unit
// Widths, fixed-point constants, datapath opcodes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package ppid_pkg;

	localparam int PIX_W    = 16;
	localparam int COEF_W   = 24;
	localparam int ERR_W    = 24;
	localparam int DRV_W    = 25;
	localparam int SAT_W    = 26;
	localparam int HEAD_W   = 13;
	localparam int FRAME_W  = 5;
	localparam int CNT_W    = 5;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 24;
	localparam int MUL_W    = 30;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int MM_W     = 27;
	localparam int U_W      = 42;
	localparam int SQ_W     = 56;
	localparam int CW       = 40;
	localparam int ZW       = 30;
	localparam int TS_W     = 29;

	localparam int ANGLE_START_FRAME = 16;
	localparam int CORDIC_STEPS      = 16;
	localparam int SQRT_ITERS        = 28;

	// floor(s/3) == (s * RECIP3) >> RECIP3_SH for every s below 2^19
	localparam logic [20:0] RECIP3    = 21'd349526;
	localparam int          RECIP3_SH = 20;

	localparam logic [ERR_W-1:0] DEADBAND = 24'd16384;
	localparam logic [ERR_W-1:0] ERR_MAX  = 24'hFFFFFF;
	localparam logic signed [ZW-1:0] PI_Q24      = 30'sd52707179;
	localparam logic signed [ZW-1:0] HALF_PI_Q24 = 30'sd26353589;
	localparam logic signed [SAT_W-1:0] ESAT_MAX = 26'sh1FFFFFF;
	localparam logic signed [SAT_W-1:0] ESAT_MIN = -26'sh2000000;

	localparam logic [15:0] RST_TARGET_X    = 16'd0;
	localparam logic [15:0] RST_TARGET_Y    = 16'd0;
	localparam logic [23:0] RST_COEF_NOW    = 24'd174816;
	localparam logic [23:0] RST_COEF_PREV   = 24'd287;
	localparam logic [23:0] RST_COEF_PREV2  = 24'hFD563E;
	localparam logic [23:0] RST_WINDUP_GAIN = 24'd665335;
	localparam logic [23:0] RST_DRIVE_LIMIT = 24'd353894;
	localparam logic [15:0] RST_PIXEL_SCALE = 16'd4224;

	typedef enum logic [IDX_W-1:0] {
		REG_TARGET_X, REG_TARGET_Y, REG_COEF_NOW, REG_COEF_PREV,
		REG_COEF_PREV2, REG_WINDUP_GAIN, REG_DRIVE_LIMIT, REG_PIXEL_SCALE
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_IDLE, OP_FX, OP_FY, OP_EX, OP_EY, OP_SQX, OP_SQY, OP_SQ0, OP_SQRT,
		OP_ERR, OP_P1, OP_P2, OP_P3, OP_U, OP_ES, OP_T, OP_DRV, OP_CLR,
		OP_AD, OP_BC, OP_AC, OP_BD, OP_CI, OP_CORD, OP_HD, OP_DONE
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             take;
		logic [CNT_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic angle_en;
	} stat_t;

	function automatic logic signed [ZW-1:0] atan_q24(input logic [CNT_W-1:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:  r = 30'sd13176795;
			5'd1:  r = 30'sd7778716;
			5'd2:  r = 30'sd4110060;
			5'd3:  r = 30'sd2086331;
			5'd4:  r = 30'sd1047214;
			5'd5:  r = 30'sd524117;
			5'd6:  r = 30'sd262123;
			5'd7:  r = 30'sd131069;
			5'd8:  r = 30'sd65536;
			5'd9:  r = 30'sd32768;
			5'd10: r = 30'sd16384;
			5'd11: r = 30'sd8192;
			5'd12: r = 30'sd4096;
			5'd13: r = 30'sd2048;
			5'd14: r = 30'sd1024;
			5'd15: r = 30'sd512;
			5'd16: r = 30'sd256;
			5'd17: r = 30'sd128;
			5'd18: r = 30'sd64;
			5'd19: r = 30'sd32;
			5'd20: r = 30'sd16;
			5'd21: r = 30'sd8;
			5'd22: r = 30'sd4;
			5'd23: r = 30'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[design/ppid_ctrl.sv]
// ----------------------------------------------------------------------------
// ppid_ctrl : sequencer of the polar PID drive unit
// Steps the datapath through filter, distance, PID, angle and hand-over.
// ----------------------------------------------------------------------------
module ppid_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  ppid_pkg::stat_t stat,
	output ppid_pkg::cmd_t  cmd
);
	import ppid_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FX, ST_FY, ST_EX, ST_EY, ST_SQX, ST_SQY, ST_SQ0, ST_SQRT,
		ST_ERR, ST_P1, ST_P2, ST_P3, ST_U, ST_ES, ST_T, ST_DRV, ST_CLR,
		ST_AD, ST_BC, ST_AC, ST_BD, ST_CI, ST_CORD, ST_HD, ST_DONE
	} state_t;

	localparam int CORD_N = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.take = (state_q == ST_IDLE) && in_valid;
		cmd.idx  = cnt_q;
		unique case (state_q)
			ST_IDLE: cmd.op = OP_IDLE;
			ST_FX:   cmd.op = OP_FX;
			ST_FY:   cmd.op = OP_FY;
			ST_EX:   cmd.op = OP_EX;
			ST_EY:   cmd.op = OP_EY;
			ST_SQX:  cmd.op = OP_SQX;
			ST_SQY:  cmd.op = OP_SQY;
			ST_SQ0:  cmd.op = OP_SQ0;
			ST_SQRT: cmd.op = OP_SQRT;
			ST_ERR:  cmd.op = OP_ERR;
			ST_P1:   cmd.op = OP_P1;
			ST_P2:   cmd.op = OP_P2;
			ST_P3:   cmd.op = OP_P3;
			ST_U:    cmd.op = OP_U;
			ST_ES:   cmd.op = OP_ES;
			ST_T:    cmd.op = OP_T;
			ST_DRV:  cmd.op = OP_DRV;
			ST_CLR:  cmd.op = OP_CLR;
			ST_AD:   cmd.op = OP_AD;
			ST_BC:   cmd.op = OP_BC;
			ST_AC:   cmd.op = OP_AC;
			ST_BD:   cmd.op = OP_BD;
			ST_CI:   cmd.op = OP_CI;
			ST_CORD: cmd.op = OP_CORD;
			ST_HD:   cmd.op = OP_HD;
			ST_DONE: cmd.op = slot_free ? OP_DONE : OP_IDLE;
			default: cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_FX;
				ST_FX:   state_q <= ST_FY;
				ST_FY:   state_q <= ST_EX;
				ST_EX:   state_q <= ST_EY;
				ST_EY:   state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SQ0;
				ST_SQ0: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SQRT_ITERS - 1)) state_q <= ST_ERR;
				end
				ST_ERR:  state_q <= ST_P1;
				ST_P1:   state_q <= stat.active ? ST_P2 : ST_CLR;
				ST_P2:   state_q <= ST_P3;
				ST_P3:   state_q <= ST_U;
				ST_U:    state_q <= ST_ES;
				ST_ES:   state_q <= ST_T;
				ST_T:    state_q <= ST_DRV;
				ST_DRV:  state_q <= stat.angle_en ? ST_AD : ST_DONE;
				ST_CLR:  state_q <= ST_DONE;
				ST_AD:   state_q <= ST_BC;
				ST_BC:   state_q <= ST_AC;
				ST_AC:   state_q <= ST_BD;
				ST_BD:   state_q <= ST_CI;
				ST_CI: begin
					cnt_q   <= '0;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CORD_N - 1)) state_q <= ST_HD;
				end
				ST_HD:   state_q <= ST_DONE;
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[design/ppid_dpath.sv]
// ----------------------------------------------------------------------------
// ppid_dpath : datapath of the polar PID drive unit
// Config registers, history, one shared multiplier, square root and CORDIC.
// ----------------------------------------------------------------------------
module ppid_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ppid_pkg::cmd_t                         cmd,
	output ppid_pkg::stat_t                        stat,
	input  logic                                   cfg_we,
	input  logic [ppid_pkg::IDX_W-1:0]             cfg_idx,
	input  logic [ppid_pkg::CFG_W-1:0]             cfg_wdata,
	input  logic [ppid_pkg::PIX_W-1:0]             in_x,
	input  logic [ppid_pkg::PIX_W-1:0]             in_y,
	output logic signed [ppid_pkg::DRV_W-1:0]      out_drive,
	output logic signed [ppid_pkg::HEAD_W-1:0]     out_heading,
	output logic [ppid_pkg::ERR_W-1:0]             out_err,
	output logic                                   out_active
);
	import ppid_pkg::*;

	logic [PIX_W-1:0]         tx_q, ty_q, sc_q;
	logic [COEF_W-1:0]        cn_q, cp_q, cp2_q, wg_q, lim_q;
	logic [PIX_W-1:0]         pin_x_q, pin_y_q, hx0_q, hx1_q, hy0_q, hy1_q, fx_q, fy_q;
	logic [ERR_W-1:0]         eh0_q, eh1_q, e_q;
	logic signed [DRV_W-1:0]  dh0_q, dh1_q, drive_q;
	logic signed [SAT_W-1:0]  sh0_q, sh1_q, es_q;
	logic [FRAME_W-1:0]       frame_q;
	logic signed [MM_W-1:0]   ex_q, ey_q;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic [SQ_W-1:0]          sqn_q, sres_q, sbit_q;
	logic                     active_q, zero_q;
	logic signed [U_W-1:0]    u_q;
	logic signed [CW-1:0]     yv_q, cx_q, cy_q;
	logic signed [ZW-1:0]     cz_q;
	logic signed [HEAD_W-1:0] heading_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic [17:0]              sum3x, sum3y;
	logic [16:0]              sum2x, sum2y;
	logic [PIX_W-1:0]         filt;
	logic signed [16:0]       dx, dy, cdx, cdy;
	logic [ERR_W-1:0]         esat;
	logic [SQ_W-1:0]          trial;
	logic signed [PROD_W-1:0] prod_rnd6, acc_rnd16, prod_rnd16;
	logic signed [U_W-1:0]    lim_s, usat, udiff, vsum, vclamp;
	logic signed [SAT_W-1:0]  es_new;
	logic signed [TS_W-1:0]   tsum;
	logic signed [CW-1:0]     xv;
	logic signed [ZW-1:0]     ang, ang_m, ang_r;

	assign stat.active   = active_q;
	assign stat.angle_en = (frame_q >= FRAME_W'(ANGLE_START_FRAME));

	assign sum3x = 18'(pin_x_q) + 18'(hx0_q) + 18'(hx1_q) + 18'd1;
	assign sum3y = 18'(pin_y_q) + 18'(hy0_q) + 18'(hy1_q) + 18'd1;
	assign sum2x = 17'(pin_x_q) + 17'(hx0_q) + 17'd1;
	assign sum2y = 17'(pin_y_q) + 17'(hy0_q) + 17'd1;

	// filtered coordinate: x while FY runs, y while EX runs
	always_comb begin
		if (frame_q == FRAME_W'(1))
			filt = (cmd.op == OP_FY) ? pin_x_q : pin_y_q;
		else if (frame_q == FRAME_W'(2))
			filt = (cmd.op == OP_FY) ? sum2x[16:1] : sum2y[16:1];
		else
			filt = prod_q[RECIP3_SH +: PIX_W];
	end

	assign dx  = $signed({1'b0, tx_q}) - $signed({1'b0, fx_q});
	assign dy  = $signed({1'b0, ty_q}) - $signed({1'b0, fy_q});
	assign cdx = $signed({1'b0, fx_q}) - $signed({1'b0, hx0_q});
	assign cdy = $signed({1'b0, fy_q}) - $signed({1'b0, hy0_q});

	assign esat  = (sres_q > SQ_W'(ERR_MAX)) ? ERR_MAX : sres_q[ERR_W-1:0];
	assign trial = sres_q + sbit_q;

	assign prod_rnd6  = (prod_q + PROD_W'(32)) >>> 6;
	assign acc_rnd16  = (acc_q + PROD_W'(32768)) >>> 16;
	assign prod_rnd16 = (prod_q + PROD_W'(32768)) >>> 16;

	assign lim_s = U_W'($signed({1'b0, lim_q}));
	always_comb begin
		if (u_q >= lim_s)       usat = lim_s;
		else if (u_q <= -lim_s) usat = -lim_s;
		else                    usat = u_q;
		udiff = usat - u_q;
		if (udiff > U_W'(ESAT_MAX))      es_new = ESAT_MAX;
		else if (udiff < U_W'(ESAT_MIN)) es_new = ESAT_MIN;
		else                             es_new = udiff[SAT_W-1:0];
		tsum = TS_W'(es_q) + (TS_W'(sh0_q) <<< 1) + TS_W'(sh1_q);
		vsum = u_q + prod_rnd16[U_W-1:0];
		if (vsum >= lim_s)       vclamp = lim_s;
		else if (vsum <= -lim_s) vclamp = -lim_s;
		else                     vclamp = vsum;
	end

	assign xv = acc_q[CW-1:0] + prod_q[CW-1:0];

	always_comb begin
		ang = zero_q ? '0 : cz_q;
		if (ang > HALF_PI_Q24)       ang_m = PI_Q24 - ang;
		else if (ang < -HALF_PI_Q24) ang_m = -PI_Q24 - ang;
		else                         ang_m = ang;
		ang_r = (ang_m + ZW'(4096)) >>> 13;
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_FX: begin
				mul_a = MUL_W'($signed({1'b0, sum3x}));
				mul_b = MUL_W'($signed({1'b0, RECIP3}));
			end
			OP_FY: begin
				mul_a = MUL_W'($signed({1'b0, sum3y}));
				mul_b = MUL_W'($signed({1'b0, RECIP3}));
			end
			OP_EX: begin
				mul_a = MUL_W'(dx);
				mul_b = MUL_W'($signed({1'b0, sc_q}));
			end
			OP_EY: begin
				mul_a = MUL_W'(dy);
				mul_b = MUL_W'($signed({1'b0, sc_q}));
			end
			OP_SQX: begin
				mul_a = MUL_W'(ex_q);
				mul_b = MUL_W'(ex_q);
			end
			OP_SQY: begin
				mul_a = MUL_W'(ey_q);
				mul_b = MUL_W'(ey_q);
			end
			OP_ERR: begin
				mul_a = MUL_W'($signed(cn_q));
				mul_b = MUL_W'($signed({1'b0, esat}));
			end
			OP_P1: begin
				mul_a = MUL_W'($signed(cp_q));
				mul_b = MUL_W'($signed({1'b0, eh0_q}));
			end
			OP_P2: begin
				mul_a = MUL_W'($signed(cp2_q));
				mul_b = MUL_W'($signed({1'b0, eh1_q}));
			end
			OP_T: begin
				mul_a = MUL_W'($signed({1'b0, wg_q}));
				mul_b = MUL_W'(tsum);
			end
			OP_AD: begin
				mul_a = MUL_W'(dx);
				mul_b = MUL_W'(cdy);
			end
			OP_BC: begin
				mul_a = MUL_W'(dy);
				mul_b = MUL_W'(cdx);
			end
			OP_AC: begin
				mul_a = MUL_W'(dx);
				mul_b = MUL_W'(cdx);
			end
			OP_BD: begin
				mul_a = MUL_W'(dy);
				mul_b = MUL_W'(cdy);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// configuration and controller history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q    <= RST_TARGET_X;
			ty_q    <= RST_TARGET_Y;
			cn_q    <= RST_COEF_NOW;
			cp_q    <= RST_COEF_PREV;
			cp2_q   <= RST_COEF_PREV2;
			wg_q    <= RST_WINDUP_GAIN;
			lim_q   <= RST_DRIVE_LIMIT;
			sc_q    <= RST_PIXEL_SCALE;
			hx0_q   <= '0;
			hx1_q   <= '0;
			hy0_q   <= '0;
			hy1_q   <= '0;
			eh0_q   <= '0;
			eh1_q   <= '0;
			dh0_q   <= '0;
			dh1_q   <= '0;
			sh0_q   <= '0;
			sh1_q   <= '0;
			frame_q <= FRAME_W'(1);
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_TARGET_X:    tx_q  <= cfg_wdata[PIX_W-1:0];
					REG_TARGET_Y:    ty_q  <= cfg_wdata[PIX_W-1:0];
					REG_COEF_NOW:    cn_q  <= cfg_wdata;
					REG_COEF_PREV:   cp_q  <= cfg_wdata;
					REG_COEF_PREV2:  cp2_q <= cfg_wdata;
					REG_WINDUP_GAIN: wg_q  <= cfg_wdata;
					REG_DRIVE_LIMIT: lim_q <= cfg_wdata;
					REG_PIXEL_SCALE: sc_q  <= cfg_wdata[PIX_W-1:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_DRV: begin
					eh1_q <= eh0_q;
					eh0_q <= e_q;
					dh1_q <= dh0_q;
					dh0_q <= vclamp[DRV_W-1:0];
					sh1_q <= sh0_q;
					sh0_q <= es_q;
				end
				OP_CLR: begin
					eh0_q <= '0;
					eh1_q <= '0;
					dh0_q <= '0;
					dh1_q <= '0;
					sh0_q <= '0;
					sh1_q <= '0;
				end
				OP_DONE: begin
					// the first frame fills both taps with its own position
					hx1_q <= (frame_q == FRAME_W'(1)) ? fx_q : hx0_q;
					hy1_q <= (frame_q == FRAME_W'(1)) ? fy_q : hy0_q;
					hx0_q <= fx_q;
					hy0_q <= fy_q;
					if (frame_q != '1) frame_q <= frame_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (cmd.op == OP_ERR) begin
			active_q <= (esat > DEADBAND);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pin_x_q <= in_x;
			pin_y_q <= in_y;
		end
		case (cmd.op)
			OP_FX:  heading_q <= '0;
			OP_FY:  fx_q <= filt;
			OP_EX:  fy_q <= filt;
			OP_EY:  ex_q <= prod_rnd6[MM_W-1:0];
			OP_SQX: ey_q <= prod_rnd6[MM_W-1:0];
			OP_SQY: acc_q <= prod_q;
			OP_SQ0: begin
				sqn_q  <= SQ_W'(acc_q) + SQ_W'(prod_q);
				sres_q <= '0;
				sbit_q <= SQ_W'(1) << 54;
			end
			OP_SQRT: begin
				if (sqn_q >= trial) begin
					sqn_q  <= sqn_q - trial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			OP_ERR: e_q <= esat;
			OP_P1:  acc_q <= prod_q;
			OP_P2:  acc_q <= acc_q + prod_q;
			OP_P3:  acc_q <= acc_q + prod_q;
			OP_U:   u_q <= U_W'(dh1_q) + acc_rnd16[U_W-1:0];
			OP_ES:  es_q <= es_new;
			OP_DRV: drive_q <= vclamp[DRV_W-1:0];
			OP_CLR: drive_q <= '0;
			OP_BC:  acc_q <= prod_q;
			OP_AC:  yv_q <= acc_q[CW-1:0] - prod_q[CW-1:0];
			OP_BD:  acc_q <= prod_q;
			OP_CI: begin
				zero_q <= (xv == '0) && (yv_q == '0);
				if (xv < 0) begin
					cx_q <= -xv;
					cy_q <= -yv_q;
					cz_q <= (yv_q >= 0) ? PI_Q24 : -PI_Q24;
				end else begin
					cx_q <= xv;
					cy_q <= yv_q;
					cz_q <= '0;
				end
			end
			OP_CORD: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + (cy_q >>> cmd.idx);
					cy_q <= cy_q - (cx_q >>> cmd.idx);
					cz_q <= cz_q + atan_q24(cmd.idx);
				end else begin
					cx_q <= cx_q - (cy_q >>> cmd.idx);
					cy_q <= cy_q + (cx_q >>> cmd.idx);
					cz_q <= cz_q - atan_q24(cmd.idx);
				end
			end
			OP_HD:  heading_q <= ang_r[HEAD_W-1:0];
			OP_DONE: begin
				out_drive   <= drive_q;
				out_heading <= heading_q;
				out_err     <= e_q;
				out_active  <= active_q;
			end
			default: ;
		endcase
	end

endmodule

[design/polar_pid_antiwindup_filtered_unit.sv]
// ----------------------------------------------------------------------------
// polar_pid_antiwindup_filtered_unit : polar PID drive controller
// Filtered position in, saturated radial drive and heading correction out.
// ----------------------------------------------------------------------------
// Paths: an item inside the deadband clears the history; otherwise the PID runs,
//   and from frame 16 on the heading correction is computed too (28 square-root
//   steps, 16 CORDIC steps, one shared 30x30 multiplier).
// Throughput: one item at a time; a result held in the output register stalls
//   the next one.
// Reset: asynchronous, active low; config, history and control registers reset.
module polar_pid_antiwindup_filtered_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pos_x [15:0], pos_y [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // drive [24:0], heading_corr [37:25],
	                               // radial_error [61:38], active [62], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import ppid_pkg::*;

	cmd_t                     cmd;
	stat_t                    stat;
	logic signed [DRV_W-1:0]  drive;
	logic signed [HEAD_W-1:0] heading_corr;
	logic [ERR_W-1:0]         radial_error;
	logic                     active;

	// always writable, so the host must write registers only while no item is in work
	assign cfg_ready = 1'b1;

	ppid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ppid_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_idx     (cfg_index),
		.cfg_wdata   (cfg_data),
		.in_x        (s_tdata[15:0]),
		.in_y        (s_tdata[31:16]),
		.out_drive   (drive),
		.out_heading (heading_corr),
		.out_err     (radial_error),
		.out_active  (active)
	);

	// pack the result item, highest field first
	assign m_tdata = {1'b0, active, radial_error, heading_corr, drive};

	// inside the deadband the controller must stay silent
	a_deadband_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !active |-> drive == '0 && heading_corr == '0)
		else $error("drive or heading set outside active mode");

	// active flag tracks the deadband threshold
	a_active_thr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> active == (radial_error > DEADBAND))
		else $error("active flag disagrees with radial error");

	// hold off new items while one is in work
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

endmodule

[tb/ppid_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppid_checker : drive-result predictor and scoreboard
// Watches the position, result and register channels of the polar PID unit,
// computes each frame's drive, heading correction, radial error and active flag
// with its own copy of the controller state, and compares each result.
// ----------------------------------------------------------------------------
module ppid_checker
	import ppid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          n_results,
	output int          n_active,
	output int          n_heading
);

	// first member sits in the top bits: active [62] down to drive [24:0]
	typedef struct packed {
		logic                     active;
		logic [ERR_W-1:0]         rad;
		logic signed [HEAD_W-1:0] heading;
		logic signed [DRV_W-1:0]  drive;
	} drive_res_t;

	localparam longint ARCTAN_Q24 [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	drive_res_t drive_due[$];

	// controller registers
	logic [15:0] tgt_x, tgt_y, mm_per_px;
	logic [23:0] gain_e0, gain_e1, gain_e2, aw_gain, lim_reg;

	// controller history
	longint fx0, fx1, fy0, fy1;
	longint e_h0, e_h1, u_h0, u_h1, es_h0, es_h1;
	int     frame_no;

	function automatic longint round_shr(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint vec_angle(input longint y, input longint x);
		longint z, t;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y > 0) begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				x = t;
				z += ARCTAN_Q24[i];
			end else begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				x = t;
				z -= ARCTAN_Q24[i];
			end
		end
		return z;
	endfunction

	function automatic longint clip_sym(input longint u, input longint lim);
		if (u >= lim) return lim;
		if (u <= -lim) return -lim;
		return u;
	endfunction

	function automatic drive_res_t next_drive(input logic [15:0] x_in, input logic [15:0] y_in);
		drive_res_t r;
		longint px, py, ex, ey, e, drv, head, lim, u, usat, es, corr, a, b, c, d, ang;
		longint unsigned rad;
		logic act;
		px = x_in;
		py = y_in;
		drv = 0;
		head = 0;
		if (frame_no == 1) begin
			fx0 = px; fx1 = px; fy0 = py; fy1 = py;
		end else if (frame_no == 2) begin
			px = (px + fx0 + 1) >> 1;
			py = (py + fy0 + 1) >> 1;
		end else begin
			px = (px + fx0 + fx1 + 1) / 3;
			py = (py + fy0 + fy1 + 1) / 3;
		end
		ex = round_shr((longint'(tgt_x) - px) * longint'(mm_per_px), 6);
		ey = round_shr((longint'(tgt_y) - py) * longint'(mm_per_px), 6);
		rad = int_sqrt(longint'(ex * ex) + longint'(ey * ey));
		e = (rad > 64'hFFFFFF) ? 64'hFFFFFF : longint'(rad);
		act = e > longint'(DEADBAND);
		if (act) begin
			lim = longint'(lim_reg);
			u = u_h1 + round_shr(longint'($signed(gain_e0)) * e
				+ longint'($signed(gain_e1)) * e_h0
				+ longint'($signed(gain_e2)) * e_h1, 16);
			usat = clip_sym(u, lim);
			es = usat - u;
			if (es > longint'(ESAT_MAX)) es = ESAT_MAX;
			if (es < longint'(ESAT_MIN)) es = ESAT_MIN;
			corr = round_shr(longint'(aw_gain) * (es + 2 * es_h0 + es_h1), 16);
			drv = clip_sym(u + corr, lim);
			e_h1 = e_h0; e_h0 = e;
			u_h1 = u_h0; u_h0 = drv;
			es_h1 = es_h0; es_h0 = es;
			if (frame_no >= ANGLE_START_FRAME) begin
				a = longint'(tgt_x) - px;
				b = longint'(tgt_y) - py;
				c = px - fx0;
				d = py - fy0;
				ang = vec_angle(a * d - b * c, a * c + b * d);
				// fold into the right half-plane
				if (ang > longint'(HALF_PI_Q24)) ang = longint'(PI_Q24) - ang;
				else if (ang < -longint'(HALF_PI_Q24)) ang = -longint'(PI_Q24) - ang;
				head = round_shr(ang, 13);
			end
		end else begin
			e_h0 = 0; e_h1 = 0; u_h0 = 0; u_h1 = 0; es_h0 = 0; es_h1 = 0;
		end
		fx1 = fx0; fx0 = px;
		fy1 = fy0; fy0 = py;
		if (frame_no < 31) frame_no++;
		r.drive   = drv[DRV_W-1:0];
		r.heading = head[HEAD_W-1:0];
		r.rad     = e[ERR_W-1:0];
		r.active  = act;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (fail_count < 30)
			$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_res_t got, want;
		if (!arst_n) begin
			tgt_x = RST_TARGET_X; tgt_y = RST_TARGET_Y; mm_per_px = RST_PIXEL_SCALE;
			gain_e0 = RST_COEF_NOW; gain_e1 = RST_COEF_PREV; gain_e2 = RST_COEF_PREV2;
			aw_gain = RST_WINDUP_GAIN; lim_reg = RST_DRIVE_LIMIT;
			fx0 = 0; fx1 = 0; fy0 = 0; fy1 = 0;
			e_h0 = 0; e_h1 = 0; u_h0 = 0; u_h1 = 0; es_h0 = 0; es_h1 = 0;
			frame_no = 1;
			drive_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_TARGET_X:    tgt_x = cfg_data[15:0];
					REG_TARGET_Y:    tgt_y = cfg_data[15:0];
					REG_COEF_NOW:    gain_e0 = cfg_data;
					REG_COEF_PREV:   gain_e1 = cfg_data;
					REG_COEF_PREV2:  gain_e2 = cfg_data;
					REG_WINDUP_GAIN: aw_gain = cfg_data;
					REG_DRIVE_LIMIT: lim_reg = cfg_data;
					REG_PIXEL_SCALE: mm_per_px = cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[62:0];
				if (drive_due.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, 0);
				end else begin
					want = drive_due.pop_front();
					n_results++;
					if (want.active) n_active++;
					if (want.heading != 0) n_heading++;
					if (got.drive !== want.drive)
						report_mismatch("drive", got.drive, want.drive);
					if (got.heading !== want.heading)
						report_mismatch("heading_corr", got.heading, want.heading);
					if (got.rad !== want.rad)
						report_mismatch("radial_error", got.rad, want.rad);
					if (got.active !== want.active)
						report_mismatch("active", got.active, want.active);
				end
			end
			if (s_tvalid && s_tready)
				drive_due.push_back(next_drive(s_tdata[15:0], s_tdata[31:16]));
		end
		pending = drive_due.size();
	end

	initial begin
		fail_count = 0;
		pending = 0;
		n_results = 0;
		n_active = 0;
		n_heading = 0;
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : testbench for the polar PID drive unit
// Streams particle positions through several register settings, including
// the extremes, with random gaps and stalls on both streams; a checker beside
// the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import ppid_pkg::*;

	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 310;
	localparam int SETTLE      = 90;     // a little over the slowest item latency
	localparam int HOLD_CYCLES = 400;
	localparam int STUCK_LIMIT = 4000;   // cycles with no item moving anywhere

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // pos_x [15:0], pos_y [31:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;    // drive [24:0], heading_corr [37:25],
	                         // radial_error [61:38], active [62]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	int fail_count, pending, n_results, n_active, n_heading;
	int stuck;
	bit calm;         // no idling on either stream while set
	bit hold_req;     // ask the receiver for one long hold-off
	int walk_x, walk_y, aim_x, aim_y;

	polar_pid_antiwindup_filtered_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ppid_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.n_results(n_results), .n_active(n_active), .n_heading(n_heading)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Write one register and hold cfg_valid high; the caller drops it.
	task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Load all eight registers for one phase; extremes sit in phases 1 to 3.
	task automatic load_phase(input int ph);
		logic [23:0] v [8];
		case (ph)
			0: v = '{24'd32000, 24'd20000, RST_COEF_NOW, RST_COEF_PREV,
				RST_COEF_PREV2, RST_WINDUP_GAIN, RST_DRIVE_LIMIT, 24'd4224};
			1: v = '{24'd0, 24'd0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
				24'hFFFFFF, 24'hFFFFFF, 24'hFFFF};
			2: v = '{24'd65535, 24'd65535, 24'h800000, 24'h7FFFFF, 24'h800000,
				24'd0, 24'd0, 24'd9000};
			3: v = '{24'd1000, 24'd64000, RST_COEF_NOW, RST_COEF_PREV,
				RST_COEF_PREV2, RST_WINDUP_GAIN, RST_DRIVE_LIMIT, 24'd0};
			default: begin
				v[0] = $urandom_range(0, 65535);
				v[1] = $urandom_range(0, 65535);
				for (int i = 2; i < 7; i++) v[i] = $urandom_range(0, 24'hFFFFFF);
				v[5] = $urandom_range(0, 24'h0FFFFF);
				v[6] = $urandom_range(24'h8000, 24'h1FFFFF);
				v[7] = $urandom_range(1000, 30000);
			end
		endcase
		for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), v[i]);
		cfg_valid <= 1'b0;
		aim_x = v[0][15:0];
		aim_y = v[1][15:0];
	endtask

	// Offer one position item, idling first now and then.
	task automatic send_pos(input int x, input int y);
		if (!calm && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {x[15:0], y[15:0]} == 0 ? 32'd0 : {y[15:0], x[15:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Wait until every predicted result has arrived, then let the unit settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int clip16(input int v);
		return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
	endfunction

	// Mostly a smooth walk so the filter and heading see real trajectories,
	// with jumps near the target and the odd position anywhere in the field.
	task automatic next_walk();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			walk_x = clip16(walk_x + $urandom_range(0, 400) - 200);
			walk_y = clip16(walk_y + $urandom_range(0, 400) - 200);
		end else if (r < 80) begin
			walk_x = clip16(aim_x + $urandom_range(0, 600) - 300);
			walk_y = clip16(aim_y + $urandom_range(0, 600) - 300);
		end else begin
			walk_x = $urandom_range(0, 65535);
			walk_y = $urandom_range(0, 65535);
		end
	endtask

	// Receiver: random stalls, one long hold-off on request.
	initial begin
		bit held;
		held = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 11);
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
			$display("[polar_pid_antiwindup_filtered_unit] ERROR");
			$finish;
		end
	end

	initial begin
		stuck = 0;
		calm = 0;
		hold_req = 0;
		walk_x = 0;
		walk_y = 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TARGET_X;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			load_phase(ph);
			calm = (ph == 4);
			hold_req = (ph == 2);
			if (ph == 0) begin
				// on target twice: inside the deadband
				send_pos(aim_x, aim_y);
				send_pos(aim_x, aim_y);
				// field corners
				send_pos(0, 0);
				send_pos(65535, 65535);
				send_pos(0, 65535);
				send_pos(65535, 0);
				// park far away: heading starts at frame 16 with no step,
				// so the atan2 vector is zero
				repeat (14) send_pos(1000, 1000);
				// then move sideways and back toward the target
				send_pos(1400, 1000);
				send_pos(1800, 1300);
				send_pos(aim_x, aim_y);
				walk_x = 1800;
				walk_y = 1300;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				next_walk();
				send_pos(walk_x, walk_y);
			end
		end

		drain();
		$display("covered %0d positions over %0d register settings", n_results, N_PHASES);
		$display("%0d with the controller running, %0d with a heading correction",
			n_active, n_heading);
		if (fail_count == 0 && pending == 0) begin
			$display("[polar_pid_antiwindup_filtered_unit] OK");
		end else begin
			$display("[polar_pid_antiwindup_filtered_unit] ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
design/ppid_pkg.sv
design/ppid_ctrl.sv
design/ppid_dpath.sv
design/polar_pid_antiwindup_filtered_unit.sv
tb/ppid_checker.sv
tb/tb_top.sv
